/* hw/rtl/ledw_pkg.sv */
// Shared types, constants and a helper function for the LED driver register writer.
package ledw_pkg;

  localparam int NUM_DIGITS = 8;
  localparam int NUM_CHIPS  = 4;
  localparam int DIG_AW     = (NUM_DIGITS > 2) ? $clog2(NUM_DIGITS) : 1;
  localparam int CHIP_AW    = (NUM_CHIPS > 2) ? $clog2(NUM_CHIPS) : 1;
  localparam int QDEPTH     = 2;
  localparam int QAW        = 1;

  localparam logic [4:0] ADDR_BASE_HI = 5'h0e;
  localparam logic [2:0] SUB_CTRL     = 3'd0;
  localparam logic [2:0] SUB_HIGH_MAX = 3'd2;
  localparam logic [2:0] SUB_LOW_MAX  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SUBADDR = 2'd1,
    PH_DATA    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_CTRL = 2'd1,
    WK_HIGH = 2'd2,
    WK_LOW  = 2'd3
  } write_kind_t;

  typedef struct packed {
    write_kind_t kind;
    logic [1:0]  chip;
    logic [2:0]  digit;
    logic [7:0]  data;
    logic        open_ok;
    logic        bad;
  } cmd_t;

  function automatic logic [4:0] current_ma(input logic [7:0] ctrl);
    logic [4:0] ma;
    ma = 5'd0;
    if (ctrl[4]) ma = ma + 5'd3;
    if (ctrl[5]) ma = ma + 5'd6;
    if (ctrl[6]) ma = ma + 5'd12;
    return ma;
  endfunction

endpackage

/* hw/rtl/ledw_front.sv */
// Front end: accepts bus bytes, tracks the transfer and classifies each byte into a command.
module ledw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_bus_byte,
  input  logic              in_first_of_transfer,
  output logic              q_push,
  output ledw_pkg::cmd_t    q_cmd,
  input  logic              q_full
);

  ledw_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] chip_r, chip_nxt;
  logic       invalid_r, invalid_nxt;
  logic [2:0] ptr_r, ptr_nxt;

  logic [1:0] addr_chip;
  logic       addr_bad;
  logic [2:0] dsel;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;
  assign addr_chip = in_bus_byte[2:1];
  assign addr_bad  = (in_bus_byte[7:3] != ledw_pkg::ADDR_BASE_HI)
                     || ({1'b0, addr_chip} >= 3'(ledw_pkg::NUM_CHIPS));
  assign dsel      = {chip_r, ~ptr_r[0]};

  always_comb begin
    phase_nxt   = phase_r;
    chip_nxt    = chip_r;
    invalid_nxt = invalid_r;
    ptr_nxt     = ptr_r;
    q_cmd       = '0;
    q_cmd.kind  = ledw_pkg::WK_NONE;
    q_cmd.data  = in_bus_byte;
    if (in_first_of_transfer) begin
      invalid_nxt = addr_bad;
      chip_nxt    = addr_bad ? 2'd0 : addr_chip;
      phase_nxt   = ledw_pkg::PH_SUBADDR;
    end else begin
      case (phase_r)
        ledw_pkg::PH_SUBADDR: begin
          ptr_nxt   = in_bus_byte[2:0];
          phase_nxt = ledw_pkg::PH_DATA;
        end
        ledw_pkg::PH_DATA: begin
          if (!invalid_r) begin
            if (ptr_r == ledw_pkg::SUB_CTRL) begin
              q_cmd.kind = ledw_pkg::WK_CTRL;
            end else if (ptr_r <= ledw_pkg::SUB_LOW_MAX
                         && {1'b0, dsel} < 4'(ledw_pkg::NUM_DIGITS)) begin
              q_cmd.digit = dsel;
              q_cmd.kind  = (ptr_r <= ledw_pkg::SUB_HIGH_MAX) ? ledw_pkg::WK_HIGH
                                                               : ledw_pkg::WK_LOW;
            end
          end
          ptr_nxt = ptr_r + 3'd1;
        end
        default: begin
        end
      endcase
    end
    q_cmd.chip    = (phase_nxt != ledw_pkg::PH_IDLE) ? chip_nxt : 2'd0;
    q_cmd.open_ok = (phase_nxt != ledw_pkg::PH_IDLE) && !invalid_nxt;
    q_cmd.bad     = (phase_nxt != ledw_pkg::PH_IDLE) && invalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ledw_pkg::PH_IDLE;
      chip_r    <= 2'd0;
      invalid_r <= 1'b0;
      ptr_r     <= 3'd0;
    end else if (q_push) begin
      phase_r   <= phase_nxt;
      chip_r    <= chip_nxt;
      invalid_r <= invalid_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

endmodule

/* hw/rtl/ledw_fifo.sv */
// Short command queue between the front end and the back end.
module ledw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ledw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ledw_pkg::cmd_t pop_cmd,
  output logic           not_empty
);

  ledw_pkg::cmd_t          mem_r [ledw_pkg::QDEPTH];
  logic [ledw_pkg::QAW-1:0] wp_r, rp_r;
  logic [ledw_pkg::QAW:0]   cnt_r;

  assign full      = (cnt_r == (ledw_pkg::QAW+1)'(ledw_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("Command queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("Command queue read while empty.");

endmodule

/* hw/rtl/ledw_back.sv */
// Back end: applies commands to the digit and control stores and registers each result.
module ledw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ledw_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_write_kind,
  output logic [1:0]     out_chip_index,
  output logic [2:0]     out_digit_index,
  output logic [15:0]    out_digit_value,
  output logic [4:0]     out_led_current_ma,
  output logic           out_bad_chip_address
);

  logic [15:0] digit_r [ledw_pkg::NUM_DIGITS];
  logic [7:0]  ctrl_r  [ledw_pkg::NUM_CHIPS];

  logic        out_valid_r;
  logic [1:0]  kind_r, chip_out_r;
  logic [2:0]  digit_out_r;
  logic [15:0] value_r;
  logic [4:0]  ma_r;
  logic        bad_r;

  logic [ledw_pkg::DIG_AW-1:0]  didx;
  logic [ledw_pkg::CHIP_AW-1:0] cidx;
  logic [15:0] old_val, new_val;
  logic [7:0]  ctrl_now;
  logic        is_digit;

  assign q_pop    = q_valid && (!out_valid_r || out_ready);
  assign didx     = q_cmd.digit[ledw_pkg::DIG_AW-1:0];
  assign cidx     = q_cmd.chip[ledw_pkg::CHIP_AW-1:0];
  assign old_val  = digit_r[didx];
  assign is_digit = (q_cmd.kind == ledw_pkg::WK_HIGH) || (q_cmd.kind == ledw_pkg::WK_LOW);
  assign new_val  = (q_cmd.kind == ledw_pkg::WK_HIGH) ? {q_cmd.data, old_val[7:0]}
                                                      : {old_val[15:8], q_cmd.data};
  assign ctrl_now = (q_cmd.kind == ledw_pkg::WK_CTRL) ? q_cmd.data : ctrl_r[cidx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ledw_pkg::NUM_DIGITS; i++) digit_r[i] <= 16'd0;
      for (int i = 0; i < ledw_pkg::NUM_CHIPS; i++) ctrl_r[i] <= 8'd0;
    end else if (q_pop) begin
      if (is_digit) digit_r[didx] <= new_val;
      if (q_cmd.kind == ledw_pkg::WK_CTRL) ctrl_r[cidx] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r      <= q_cmd.kind;
      chip_out_r  <= q_cmd.open_ok ? q_cmd.chip : 2'd0;
      digit_out_r <= is_digit ? q_cmd.digit : 3'd0;
      value_r     <= is_digit ? new_val : 16'd0;
      ma_r        <= q_cmd.open_ok ? ledw_pkg::current_ma(ctrl_now) : 5'd0;
      bad_r       <= q_cmd.bad;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_write_kind       = kind_r;
  assign out_chip_index       = chip_out_r;
  assign out_digit_index      = digit_out_r;
  assign out_digit_value      = value_r;
  assign out_led_current_ma   = ma_r;
  assign out_bad_chip_address = bad_r;

  a_ctrl_written: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.kind == ledw_pkg::WK_CTRL |=> ctrl_r[$past(cidx)] == $past(q_cmd.data))
    else $error("Control byte not stored after a control write.");

  a_bad_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_chip_address |-> out_write_kind == ledw_pkg::WK_NONE
                                          && out_led_current_ma == 5'd0)
    else $error("Transaction with a bad chip address wrote or reported current.");

endmodule

/* hw/rtl/led_driver_i2c_register_writer_top.sv */
// Each accepted byte is queued; out_valid rises once the back end pops it and registers the
// result. Throughput: one byte per cycle while the queue is not full, set by the front
// transfer tracker and the back store update. A two-entry command queue lets the front keep
// accepting while the back waits on out_ready. Reset (synchronous, active low) returns the
// transfer to idle and clears all digit and control stores and the queue.
module led_driver_i2c_register_writer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_bus_byte,
  input  logic        in_first_of_transfer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_write_kind,
  output logic [1:0]  out_chip_index,
  output logic [2:0]  out_digit_index,
  output logic [15:0] out_digit_value,
  output logic [4:0]  out_led_current_ma,
  output logic        out_bad_chip_address
);

  logic           q_push, q_full, q_pop, q_valid;
  ledw_pkg::cmd_t push_cmd, pop_cmd;

  ledw_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_bus_byte          (in_bus_byte),
    .in_first_of_transfer (in_first_of_transfer),
    .q_push               (q_push),
    .q_cmd                (push_cmd),
    .q_full               (q_full)
  );

  ledw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  ledw_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_cmd                (pop_cmd),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_write_kind       (out_write_kind),
    .out_chip_index       (out_chip_index),
    .out_digit_index      (out_digit_index),
    .out_digit_value      (out_digit_value),
    .out_led_current_ma   (out_led_current_ma),
    .out_bad_chip_address (out_bad_chip_address)
  );

endmodule

/* bench/led_driver_i2c_register_writer_top_tb.sv */
// Self-checking testbench for the LED driver I2C register writer.
module led_driver_i2c_register_writer_top_tb;

  localparam int RANDOM_ITEMS = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] CHIP_ADDR_BASE = 8'h70;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       first;
    logic       hold;
  } bus_item_t;

  typedef struct packed {
    ledw_pkg::write_kind_t kind;
    logic [1:0]  chip;
    logic [2:0]  digit;
    logic [15:0] value;
    logic [4:0]  ma;
    logic        bad;
  } led_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_bus_byte = 8'd0;
  logic        in_first_of_transfer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_write_kind;
  logic [1:0]  out_chip_index;
  logic [2:0]  out_digit_index;
  logic [15:0] out_digit_value;
  logic [4:0]  out_led_current_ma;
  logic        out_bad_chip_address;

  bus_item_t   bytes_to_send[$];
  led_result_t expected_writes[$];
  int          total_bytes = 0;
  int          bytes_accepted = 0;
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  logic        in_took = 1'b0;

  ledw_pkg::phase_t xfer_phase = ledw_pkg::PH_IDLE;
  logic [1:0]  cur_chip = 2'd0;
  logic        chip_bad = 1'b0;
  logic [2:0]  sub_ptr = 3'd0;
  logic [15:0] digit_store[ledw_pkg::NUM_DIGITS];
  logic [7:0]  ctrl_store[ledw_pkg::NUM_CHIPS];

  led_driver_i2c_register_writer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_bus_byte(in_bus_byte),
    .in_first_of_transfer(in_first_of_transfer),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_write_kind(out_write_kind),
    .out_chip_index(out_chip_index),
    .out_digit_index(out_digit_index),
    .out_digit_value(out_digit_value),
    .out_led_current_ma(out_led_current_ma),
    .out_bad_chip_address(out_bad_chip_address)
  );

  always #5 clk = ~clk;

  function automatic led_result_t predict_register_write(input logic [7:0] b, input logic first);
    led_result_t r;
    logic [2:0]  p;
    logic [3:0]  d;
    logic [7:0]  c;
    r = '0;
    if (first) begin
      chip_bad = (b[7:3] != CHIP_ADDR_BASE[7:3]) || (int'(b[2:1]) >= ledw_pkg::NUM_CHIPS);
      cur_chip = chip_bad ? 2'd0 : b[2:1];
      xfer_phase = ledw_pkg::PH_SUBADDR;
    end else if (xfer_phase == ledw_pkg::PH_SUBADDR) begin
      sub_ptr = b[2:0];
      xfer_phase = ledw_pkg::PH_DATA;
    end else if (xfer_phase == ledw_pkg::PH_DATA) begin
      if (!chip_bad) begin
        p = sub_ptr;
        d = {1'b0, cur_chip, 1'b0} + (p[0] ? 4'd0 : 4'd1);
        if (p == ledw_pkg::SUB_CTRL) begin
          ctrl_store[cur_chip] = b;
          r.kind = ledw_pkg::WK_CTRL;
        end else if (p <= ledw_pkg::SUB_LOW_MAX && int'(d) < ledw_pkg::NUM_DIGITS) begin
          if (p <= ledw_pkg::SUB_HIGH_MAX) begin
            digit_store[d[2:0]][15:8] = b;
            r.kind = ledw_pkg::WK_HIGH;
          end else begin
            digit_store[d[2:0]][7:0] = b;
            r.kind = ledw_pkg::WK_LOW;
          end
          r.value = digit_store[d[2:0]];
          r.digit = d[2:0];
        end
      end
      sub_ptr = sub_ptr + 3'd1;
    end
    if (xfer_phase != ledw_pkg::PH_IDLE && !chip_bad) begin
      c = ctrl_store[cur_chip];
      r.chip = cur_chip;
      r.ma = (c[4] ? 5'd3 : 5'd0) + (c[5] ? 5'd6 : 5'd0) + (c[6] ? 5'd12 : 5'd0);
    end
    r.bad = (xfer_phase != ledw_pkg::PH_IDLE) && chip_bad;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("Mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic first, input logic hold = 1'b0);
    bus_item_t it;
    it.bus_byte = b;
    it.first = first;
    it.hold = hold;
    bytes_to_send.push_back(it);
  endtask

  task automatic queue_random_transfer(input logic hold);
    logic [7:0] addr;
    int         n_data;
    if ($urandom_range(99) < 85) begin
      addr = CHIP_ADDR_BASE + 8'($urandom_range(7));
    end else begin
      addr = 8'($urandom_range(255));
    end
    queue_byte(addr, 1'b1, hold);
    if ($urandom_range(99) < 5) begin
      return;
    end
    queue_byte(8'($urandom_range(255)), 1'b0);
    n_data = $urandom_range(10);
    for (int i = 0; i < n_data; i++) begin
      queue_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  always @(negedge clk) begin
    int send_idle;
    int recv_idle;
    send_idle = (bytes_accepted * 3 < total_bytes) ? 16 :
                (bytes_accepted * 3 < total_bytes * 2) ? 57 : 0;
    recv_idle = (bytes_accepted * 3 < total_bytes) ? 57 :
                (bytes_accepted * 3 < total_bytes * 2) ? 16 : 0;
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (!in_valid || in_took) begin
        if (bytes_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (bytes_to_send[0].hold && expected_writes.size() != 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(99) < send_idle) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_bus_byte <= bytes_to_send[0].bus_byte;
          in_first_of_transfer <= bytes_to_send[0].first;
          void'(bytes_to_send.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    led_result_t want;
    led_result_t got;
    logic        in_fire;
    logic        out_fire;
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    in_took <= in_fire;
    if (in_fire) begin
      expected_writes.push_back(predict_register_write(in_bus_byte, in_first_of_transfer));
      bytes_accepted <= bytes_accepted + 1;
    end
    if (out_fire) begin
      got.kind = ledw_pkg::write_kind_t'(out_write_kind);
      got.chip = out_chip_index;
      got.digit = out_digit_index;
      got.value = out_digit_value;
      got.ma = out_led_current_ma;
      got.bad = out_bad_chip_address;
      if (expected_writes.size() == 0) begin
        report_mismatch("result with nothing pending, write_kind", got.kind, 0);
      end else begin
        want = expected_writes.pop_front();
        if (got.kind != want.kind) report_mismatch("write_kind", got.kind, want.kind);
        if (got.chip != want.chip) report_mismatch("chip_index", got.chip, want.chip);
        if (got.digit != want.digit) report_mismatch("digit_index", got.digit, want.digit);
        if (got.value != want.value) report_mismatch("digit_value", got.value, want.value);
        if (got.ma != want.ma) report_mismatch("led_current_ma", got.ma, want.ma);
        if (got.bad != want.bad) report_mismatch("bad_chip_address", got.bad, want.bad);
      end
    end
    stall_cycles <= (in_fire || out_fire) ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    foreach (digit_store[i]) digit_store[i] = 16'd0;
    foreach (ctrl_store[i]) ctrl_store[i] = 8'd0;

    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h70, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h70, 1'b0);
    queue_byte(8'hab, 1'b0);
    queue_byte(8'hcd, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h66, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h77, 1'b1, 1'b1);
    queue_byte(8'hfb, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h6f, 1'b1);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h5a, 1'b0);
    queue_byte(8'h78, 1'b1);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h72, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'hc3, 1'b0);

    while (bytes_to_send.size() < RANDOM_ITEMS / 2) begin
      queue_random_transfer($urandom_range(99) < 3);
    end
    queue_random_transfer(1'b1);
    while (bytes_to_send.size() < RANDOM_ITEMS + 26) begin
      queue_random_transfer($urandom_range(99) < 3);
    end
    total_bytes = bytes_to_send.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (bytes_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
